// ===== hdl/css_pkg.sv =====
// ----------------------------------------------------------------------------
// css_pkg
// Shared types, constants and character codes for the comment span scanner.
// ----------------------------------------------------------------------------
package css_pkg;

	// counter widths
	localparam int LINE_BITS   = 20;
	localparam int COLUMN_BITS = 16;

	// result field widths (fixed by the stream format)
	localparam int SPAN_LINE_W   = 20;
	localparam int SPAN_COLUMN_W = 16;
	localparam int SPAN_LENGTH_W = 16;
	localparam int SPAN_BITS     = SPAN_LINE_W + SPAN_COLUMN_W + SPAN_LENGTH_W;
	localparam int OUT_DATA_W    = ((SPAN_BITS + 7) / 8) * 8;

	// scan modes
	localparam int MODE_W = 3;
	localparam logic [MODE_W-1:0] MODE_NORMAL = 3'd0;
	localparam logic [MODE_W-1:0] MODE_LINE   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_BLOCK  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_DQUOTE = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SQUOTE = 3'd4;

	// character codes
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_BSL   = 8'h5C;

	typedef struct packed {
		logic [MODE_W-1:0]      mode;
		logic                   pend_slash;
		logic                   pend_star;
		logic                   skip_lf;
		logic                   esc;
		logic [LINE_BITS-1:0]   cur_line;
		logic [COLUMN_BITS-1:0] cur_col;
		logic [LINE_BITS-1:0]   start_line;
		logic [COLUMN_BITS-1:0] start_col;
		logic [COLUMN_BITS-1:0] seg_len;
	} css_state_t;

	localparam css_state_t STATE_RESET = '0;

	typedef struct packed {
		logic                     valid;
		logic [SPAN_LINE_W-1:0]   line;
		logic [SPAN_COLUMN_W-1:0] column;
		logic [SPAN_LENGTH_W-1:0] length;
	} css_span_t;

endpackage

// ===== hdl/comment_span_scanner_core.sv =====
// ----------------------------------------------------------------------------
// comment_span_scanner_core
// Byte-stream comment finder: one span per comment line.
// ----------------------------------------------------------------------------
// Source text enters one byte per request on the slave side, with s_tlast on
// the final byte of a text; after that byte all position state starts over at
// line 0, column 0. LF, CR and CR LF each count as one line break. For every
// line of a "//" or block comment the block sends one span request carrying
// the zero-based start line, start column and byte length; empty lines of a
// block comment and the last line of an unclosed block comment give nothing.
// Quoted literals (double or single, backslash escapes, ended by LF; a CR in
// one is no break) are skipped. Counters saturate at their top values.
// Throughput is one byte per clock while not stalled: the mode machine is
// combinational between the input register, which holds an accepted byte,
// and the span register. The input side only stalls while a span waits in
// the output register and m_tready is low.
// ----------------------------------------------------------------------------
module comment_span_scanner_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// s_tdata: text_byte[7:0]
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,
	// s_tlast: end_of_text
	input  logic                          s_tlast,
	// m_tdata: span_line[19:0], span_column[35:20], span_length[51:36], zero pad
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [css_pkg::OUT_DATA_W-1:0] m_tdata
);
	import css_pkg::*;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// scanner state
	css_state_t state_q;
	css_state_t state_next;
	css_span_t  span;

	// output register
	logic                  out_valid_q;
	logic [SPAN_BITS-1:0]  out_span_q;

	logic advance;

	// stage 1 moves on whenever the output slot is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	css_step u_step (
		.state       (state_q),
		.text_byte   (byte_s1),
		.end_of_text (last_s1),
		.state_next  (state_next),
		.span        (span)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && span.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && span.valid) begin
			out_span_q <= {span.length, span.column, span.line};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_W'(out_span_q);

endmodule

// ===== hdl/css_step.sv =====
// ----------------------------------------------------------------------------
// css_step
// Next-state and span logic for one text byte.
// ----------------------------------------------------------------------------
module css_step (
	input  css_pkg::css_state_t state,
	input  logic [7:0]          text_byte,
	input  logic                end_of_text,
	output css_pkg::css_state_t state_next,
	output css_pkg::css_span_t  span
);
	import css_pkg::*;

	function automatic logic [COLUMN_BITS-1:0] col_inc(input logic [COLUMN_BITS-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic css_state_t line_break(input css_state_t s);
		css_state_t r;
		r = s;
		if (!(&s.cur_line))
			r.cur_line = s.cur_line + 1'b1;
		r.cur_col = '0;
		return r;
	endfunction

	function automatic css_state_t normal_byte(input css_state_t s, input logic [7:0] b);
		css_state_t r;
		r = s;
		priority if (b == CH_LF) begin
			r = line_break(r);
		end else if (b == CH_CR) begin
			r = line_break(r);
			r.skip_lf = 1'b1;
		end else if (b == CH_SLASH) begin
			r.pend_slash = 1'b1;
			r.start_line = s.cur_line;
			r.start_col  = s.cur_col;
			r.cur_col    = col_inc(s.cur_col);
		end else if (b == CH_DQ) begin
			r.mode    = MODE_DQUOTE;
			r.esc     = 1'b0;
			r.cur_col = col_inc(s.cur_col);
		end else if (b == CH_SQ) begin
			r.mode    = MODE_SQUOTE;
			r.esc     = 1'b0;
			r.cur_col = col_inc(s.cur_col);
		end else begin
			r.cur_col = col_inc(s.cur_col);
		end
		return r;
	endfunction

	css_state_t             nx;
	logic                   emit;
	logic [LINE_BITS-1:0]   e_line;
	logic [COLUMN_BITS-1:0] e_col;
	logic [COLUMN_BITS-1:0] e_len;
	logic                   is_break;
	logic [7:0]             quote;

	assign is_break = (text_byte == CH_LF) || (text_byte == CH_CR);
	assign quote    = (state.mode == MODE_DQUOTE) ? CH_DQ : CH_SQ;

	always_comb begin
		nx         = state;
		nx.skip_lf = 1'b0;
		emit       = 1'b0;
		e_line     = state.start_line;
		e_col      = state.start_col;
		e_len      = state.seg_len;
		if (state.skip_lf && text_byte == CH_LF) begin
			// tail of a CR LF pair
		end else begin
			unique case (state.mode)
				MODE_LINE: begin
					if (is_break) begin
						emit    = (state.seg_len != '0);
						nx.mode = MODE_NORMAL;
						nx      = normal_byte(nx, text_byte);
					end else begin
						nx.seg_len = col_inc(state.seg_len);
						nx.cur_col = col_inc(state.cur_col);
					end
				end
				MODE_BLOCK: begin
					if (is_break) begin
						emit = (state.seg_len != '0);
						nx   = line_break(nx);
						if (text_byte == CH_CR)
							nx.skip_lf = 1'b1;
						nx.pend_star  = 1'b0;
						nx.start_line = nx.cur_line;
						nx.start_col  = '0;
						nx.seg_len    = '0;
					end else if (state.pend_star && text_byte == CH_SLASH) begin
						nx.seg_len   = col_inc(state.seg_len);
						nx.cur_col   = col_inc(state.cur_col);
						e_len        = nx.seg_len;
						emit         = (nx.seg_len != '0);
						nx.pend_star = 1'b0;
						nx.mode      = MODE_NORMAL;
					end else begin
						nx.pend_star = (text_byte == CH_STAR);
						nx.seg_len   = col_inc(state.seg_len);
						nx.cur_col   = col_inc(state.cur_col);
					end
				end
				MODE_DQUOTE, MODE_SQUOTE: begin
					if (state.esc) begin
						nx.esc     = 1'b0;
						nx.cur_col = col_inc(state.cur_col);
					end else if (text_byte == quote) begin
						nx.mode    = MODE_NORMAL;
						nx.cur_col = col_inc(state.cur_col);
					end else if (text_byte == CH_LF) begin
						nx.mode = MODE_NORMAL;
						nx      = line_break(nx);
					end else begin
						if (text_byte == CH_BSL)
							nx.esc = 1'b1;
						nx.cur_col = col_inc(state.cur_col);
					end
				end
				default: begin
					// normal text; stray codes fall back here too
					nx.mode = MODE_NORMAL;
					if (state.pend_slash && text_byte == CH_SLASH) begin
						nx.pend_slash = 1'b0;
						nx.mode       = MODE_LINE;
						nx.seg_len    = COLUMN_BITS'(2);
						nx.cur_col    = col_inc(state.cur_col);
					end else if (state.pend_slash && text_byte == CH_STAR) begin
						nx.pend_slash = 1'b0;
						nx.pend_star  = 1'b0;
						nx.mode       = MODE_BLOCK;
						nx.seg_len    = COLUMN_BITS'(2);
						nx.cur_col    = col_inc(state.cur_col);
					end else begin
						nx.pend_slash = 1'b0;
						nx            = normal_byte(nx, text_byte);
					end
				end
			endcase
		end

		if (end_of_text) begin
			// an open line comment closes at the last byte
			if (nx.mode == MODE_LINE && !emit) begin
				emit   = (nx.seg_len != '0);
				e_line = nx.start_line;
				e_col  = nx.start_col;
				e_len  = nx.seg_len;
			end
			nx = STATE_RESET;
		end
	end

	assign state_next  = nx;
	assign span.valid  = emit;
	assign span.line   = SPAN_LINE_W'(e_line);
	assign span.column = SPAN_COLUMN_W'(e_col);
	assign span.length = SPAN_LENGTH_W'(e_len);

endmodule

// ===== hdl/css_checker.sv =====
// ----------------------------------------------------------------------------
// css_checker
// Port-level checks for the comment span scanner, bound to the top level.
// ----------------------------------------------------------------------------
module css_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [7:0]                    s_tdata,
	input logic                          s_tlast,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [css_pkg::OUT_DATA_W-1:0] m_tdata
);
	import css_pkg::*;

	// a stalled span holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("span changed while stalled");

	// spans are never empty
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[SPAN_BITS-1 -: SPAN_LENGTH_W] != '0)
		else $error("zero-length span");

	// pad bits above the span stay zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata >> SPAN_BITS) == '0)
		else $error("nonzero pad bits");

	// a draining output never blocks the byte stream
	a_flow: assert property (@(posedge clk)
		m_tready |-> s_tready)
		else $error("input stalled with output ready");

endmodule

bind comment_span_scanner_core css_checker u_css_checker (.*);
